/* src/bia_pkg.sv */
`timescale 1ns / 1ps
// Package for the bitmap ID allocator: sizes, payload structs and index helpers.
// Used by every module of the block; depends on nothing.
package bia_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int WORD_W  = (SLOTS < 32) ? SLOTS : 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WORDS   = SLOTS / WORD_W;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RES_W   = 11;
    localparam int CMP_W   = (IDX_W + 1 > RES_W) ? IDX_W + 1 : RES_W;
    localparam int DATA_W  = 32;

    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    typedef enum logic {
        REG_TAG_MASK = 1'b0,
        REG_RESERVED = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic        kind;
        logic [31:0] handle;
    } t_in_item;

    typedef struct packed {
        logic        alloc_ok;
        logic [31:0] alloc_handle;
    } t_out_item;

    typedef struct packed {
        logic             is_free;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    function automatic logic [WADDR_W-1:0] word_of(input logic [IDX_W-1:0] idx);
        return WADDR_W'(idx >> BIT_W);
    endfunction

    function automatic logic [BIT_W-1:0] bit_of(input logic [IDX_W-1:0] idx);
        return idx[BIT_W-1:0];
    endfunction

endpackage

/* src/bia_front.sv */
`timescale 1ns / 1ps
// Front stage: accepts request transfers and classifies them into commands.
// Depends on bia_pkg.
module bia_front import bia_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_enable,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_full
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic take;
    logic send;

    assign send   = r_valid && !i_cmd_full;
    assign o_full = !i_enable || (r_valid && i_cmd_full);
    assign take   = i_push && !o_full;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (send) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (take) begin
            r_cmd.is_free <= (i_item.kind == KIND_FREE);
            r_cmd.idx     <= i_item.handle[IDX_W-1:0];
        end
    end

    assign o_cmd_valid = send;
    assign o_cmd       = r_cmd;

endmodule

/* src/bia_cmd_fifo.sv */
`timescale 1ns / 1ps
// Two-entry command queue between the front stage and the allocation engine.
// Depends on bia_pkg.
module bia_cmd_fifo import bia_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

/* src/bia_engine.sv */
`timescale 1ns / 1ps
// Allocation engine: bitmap memory, word scan, free handling, tag and result register.
// Depends on bia_pkg.
module bia_engine import bia_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [RES_W-1:0] i_reserved,
    input  logic [31:0]      i_tag_mask,
    input  logic             i_cmd_empty,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    output logic             o_clearing,
    output logic             o_res_valid,
    output t_out_item        o_res,
    input  logic             i_res_pop
);

    typedef enum logic [3:0] {
        S_CLR  = 4'b0001,
        S_IDLE = 4'b0010,
        S_RD   = 4'b0100,
        S_EVAL = 4'b1000
    } t_state;

    logic [WORD_W-1:0]  r_mem [WORDS];
    logic [WORD_W-1:0]  r_rdata;

    t_state             r_state;
    logic [WADDR_W-1:0] r_addr;
    logic               r_is_free;
    logic [IDX_W-1:0]   r_idx;
    logic               r_first;
    logic               r_wrap;
    logic [IDX_W-1:0]   r_hint;
    logic [31:0]        r_tag;
    logic               r_res_valid;
    t_out_item          r_res;

    logic               we;
    logic [WORD_W-1:0]  wdata;
    logic [WORD_W-1:0]  clr_word;
    logic [WORD_W-1:0]  free_bits;
    logic [BIT_W-1:0]   ffs;
    logic               found;
    logic               last_word;
    logic               start;
    logic [31:0]        tag_next;
    logic [IDX_W-1:0]   found_idx;

    assign last_word = (r_addr == WADDR_W'(WORDS - 1));
    assign tag_next  = 32'(r_tag + 32'(SLOTS)) & i_tag_mask;
    assign start     = (r_state == S_IDLE) && !i_cmd_empty
                       && (i_cmd.is_free || !r_res_valid);
    assign found_idx = IDX_W'({r_addr, ffs});

    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            clr_word[b]  = (CMP_W'({r_addr, BIT_W'(b)}) < CMP_W'(i_reserved));
            free_bits[b] = !r_rdata[b] && (!r_first || (BIT_W'(b) >= bit_of(r_hint)));
        end
    end

    always_comb begin
        ffs = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                ffs = BIT_W'(b);
            end
        end
    end

    assign found = |free_bits;

    always_comb begin
        we    = 1'b0;
        wdata = r_rdata;
        if (r_state == S_CLR) begin
            we    = 1'b1;
            wdata = clr_word;
        end else if (r_state == S_EVAL) begin
            if (r_is_free) begin
                we    = 1'b1;
                wdata = r_rdata & ~(WORD_W'(1) << bit_of(r_idx));
            end else if (found) begin
                we    = 1'b1;
                wdata = r_rdata | (WORD_W'(1) << ffs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_addr] <= wdata;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state     <= S_CLR;
            r_addr      <= '0;
            r_hint      <= '0;
            r_tag       <= '0;
            r_res_valid <= 1'b0;
            r_first     <= 1'b0;
            r_wrap      <= 1'b0;
        end else begin
            if (i_res_pop) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    if (last_word) begin
                        r_state <= S_IDLE;
                        r_addr  <= '0;
                    end else begin
                        r_addr <= r_addr + WADDR_W'(1);
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_is_free <= i_cmd.is_free;
                        r_idx     <= i_cmd.idx;
                        r_addr    <= word_of(i_cmd.is_free ? i_cmd.idx : r_hint);
                        r_first   <= 1'b1;
                        r_wrap    <= 1'b0;
                        r_state   <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_is_free) begin
                        if (r_idx < r_hint) begin
                            r_hint <= r_idx;
                        end
                        r_tag   <= tag_next;
                        r_state <= S_IDLE;
                    end else if (found) begin
                        r_res.alloc_ok     <= 1'b1;
                        r_res.alloc_handle <= 32'(found_idx) | r_tag;
                        r_res_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end else if (!last_word) begin
                        r_addr  <= r_addr + WADDR_W'(1);
                        r_first <= 1'b0;
                        r_state <= S_RD;
                    end else if (!r_wrap) begin
                        r_tag   <= tag_next;
                        r_wrap  <= 1'b1;
                        r_first <= 1'b0;
                        r_addr  <= '0;
                        r_state <= S_RD;
                    end else begin
                        r_res.alloc_ok     <= 1'b0;
                        r_res.alloc_handle <= '1;
                        r_res_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLR;
                    r_addr  <= '0;
                end
            endcase
        end
    end

    assign o_cmd_pop   = start;
    assign o_clearing  = (r_state == S_CLR);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* src/bitmap_id_allocator.sv */
`timescale 1ns / 1ps
// Usage: requests enter through a queue-style port (i_push, o_full, i_item). A request
// transfer takes place at a clock edge with i_push high and o_full low. Kind 0 allocates
// a number, kind 1 frees the number in handle. Each allocate request yields one result
// (alloc_ok, alloc_handle) on o_result while o_empty is low; a result transfer takes
// place at an edge with i_pop high. Free requests yield no result.
// A request passes through the front stage and the command queue. The engine reads the
// bitmap memory one 32-bit word at a time, with a read state and an evaluate state for
// each word; an allocate request scans from the hint word to the last word and, when
// the map wraps, makes a second pass from word 0.
// While a result waits, free requests keep running and two more requests can be
// queued; an allocate request waits in the queue until the result register is free.
// After reset, and after each write of the reserved-count register, a clearing pass
// rewrites the bitmap; o_full stays high during it. The user must write the tag mask and
// reserved count over the APB port only while the block is idle; it does not enforce this.
// Depends on bia_pkg, bia_front, bia_cmd_fifo and bia_engine.
module bitmap_id_allocator import bia_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  t_in_item          i_item,
    output logic              o_empty,
    input  logic              i_pop,
    output t_out_item         o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [31:0]      r_tag_mask;
    logic [RES_W-1:0] r_reserved;
    logic             cfg_wr;
    logic             restart;
    t_reg_idx         reg_sel;

    logic             cmd_valid;
    t_cmd             front_cmd;
    logic             fifo_full;
    logic             fifo_empty;
    t_cmd             fifo_cmd;
    logic             cmd_pop;
    logic             clearing;
    logic             res_valid;

    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && (reg_sel == REG_RESERVED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_mask <= '0;
            r_reserved <= '0;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_TAG_MASK: r_tag_mask <= pwdata[31:0];
                REG_RESERVED: r_reserved <= pwdata[RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_TAG_MASK: prdata = r_tag_mask;
            REG_RESERVED: prdata = DATA_W'(r_reserved);
            default:      prdata = '0;
        endcase
    end

    bia_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_enable    (!clearing),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (front_cmd),
        .i_cmd_full  (fifo_full)
    );

    bia_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (front_cmd),
        .o_full  (fifo_full),
        .i_pop   (cmd_pop),
        .o_cmd   (fifo_cmd),
        .o_empty (fifo_empty)
    );

    bia_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_reserved  (r_reserved),
        .i_tag_mask  (r_tag_mask),
        .i_cmd_empty (fifo_empty),
        .i_cmd       (fifo_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (i_pop && res_valid)
    );

    assign o_empty = !res_valid;

endmodule
